// ----- rtl/core/atlcd_pkg.sv -----
package atlcd_pkg;

  // lcd command bytes
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_ENTRY      = 8'h06;
  localparam logic [7:0] LCD_CUR_SHOWN  = 8'h0F;
  localparam logic [7:0] LCD_CUR_HIDDEN = 8'h0C;
  localparam logic [7:0] LCD_LOCATE     = 8'h80;
  localparam logic [7:0] LCD_ROW1       = 8'h40;

  // what the parser decided for the accepted byte
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_PRINT   = 3'd1,
    ACT_NEWLINE = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_ERASE   = 3'd4,
    ACT_HOME    = 3'd5,
    ACT_CUR_ON  = 3'd6,
    ACT_CUR_OFF = 3'd7
  } act_e;

  // source of the lcd write loaded into the output register
  typedef enum logic [2:0] {
    EMIT_CLEAR  = 3'd0,
    EMIT_HOME   = 3'd1,
    EMIT_ENTRY  = 3'd2,
    EMIT_LOCATE = 3'd3,
    EMIT_SHADOW = 3'd4,
    EMIT_SPACE  = 3'd5,
    EMIT_CHAR   = 3'd6,
    EMIT_CURSOR = 3'd7
  } emit_sel_e;

  // cursor and shadow updates
  typedef enum logic [2:0] {
    CUR_NONE     = 3'd0,
    CUR_WRAP     = 3'd1,
    CUR_NEWLINE  = 3'd2,
    CUR_SCROLLED = 3'd3,
    CUR_GOTO     = 3'd4,
    CUR_HOME     = 3'd5,
    CUR_ADVANCE  = 3'd6
  } cur_op_e;

  // column counter used by scroll redraw and erase
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_ZERO = 2'd1,
    CNT_INC  = 2'd2,
    CNT_COL  = 2'd3
  } cnt_op_e;

  typedef struct packed {
    logic      take;
    logic      emit;
    emit_sel_e sel;
    logic      last;
    cur_op_e   cur_op;
    cnt_op_e   cnt_op;
    logic      rd_en;
    logic      erase;
  } atlcd_cmd_t;

  typedef struct packed {
    act_e act;
    logic moved;
    logic row_over;
    logic cnt_last;
    logic out_free;
  } atlcd_stat_t;

endpackage

// ----- rtl/core/atlcd_if.sv -----
// terminal byte channel
interface atlcd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

// lcd write channel
interface atlcd_wr_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [7:0] bus_value;
  logic       long_wait;
  logic       last;

  modport source (output valid, output register_select, output bus_value,
                  output long_wait, output last, input ready);
  modport sink (input valid, input register_select, input bus_value,
                input long_wait, input last, output ready);
endinterface

// ----- rtl/core/ansi_text_to_char_lcd.sv -----
// Terminal text front end for a two-line character LCD.
// char_i carries one terminal byte per transaction; lcd_o carries one LCD
// write per transaction (register_select, bus_value, long_wait, last), and
// last marks the final write caused by a byte. Bytes that cause no write
// produce no transaction on lcd_o.
// A byte is taken only while the controller is idle. After acceptance the
// controller decodes it in ST_DISP, then settles the cursor through ST_CHK and
// ST_POST for printable, newline and erase bytes, then issues one write per
// cycle while lcd_o is free. A scroll adds COLUMNS+3 writes, and erase adds
// one write per blanked cell. The rate is set by the write sequencer issuing
// at most one LCD write per cycle while lcd_o is free.
// The screen shadow sits in a small RAM read one cell per cycle while lcd_o
// is free during a scroll redraw; per-cell valid bits make unwritten cells
// read as spaces. Reset returns the parser to normal mode, clears parameters,
// homes the cursor and blanks the shadow immediately. When lcd_o stalls, the
// output register holds its write and the sequencer waits; the next byte is
// accepted as soon as the last write of the current one is registered.
module ansi_text_to_char_lcd import atlcd_pkg::*; #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  atlcd_char_if.sink   char_i,
  atlcd_wr_if.source   lcd_o
);

  atlcd_cmd_t  cmd;
  atlcd_stat_t stat;
  logic        in_ready;

  assign char_i.ready = in_ready;

  atlcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  atlcd_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .char_byte_i       (char_i.char_byte),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (lcd_o.ready),
    .out_valid_o       (lcd_o.valid),
    .register_select_o (lcd_o.register_select),
    .bus_value_o       (lcd_o.bus_value),
    .long_wait_o       (lcd_o.long_wait),
    .last_o            (lcd_o.last)
  );

`ifndef SYNTH
  // a write is only loaded when the output register can take it
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("write loaded into a full output register");

  // one byte at a time
  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_i.valid && char_i.ready) |=> !char_i.ready)
    else $error("second byte accepted while the first is in work");

  // shadow store is never read and written in the same cycle
  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> (cmd.cur_op != CUR_ADVANCE))
    else $error("shadow read and write collide");

  // long wait only on the clear command
  a_long_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lcd_o.valid && lcd_o.long_wait) |->
      (!lcd_o.register_select && lcd_o.bus_value == LCD_CLEAR))
    else $error("long wait on a write other than clear");
`endif

endmodule

// ----- rtl/core/atlcd_ram.sv -----
module atlcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/atlcd_dp.sv -----
module atlcd_dp import atlcd_pkg::*; #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  char_byte_i,
  input  atlcd_cmd_t  cmd_i,
  output atlcd_stat_t stat_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        register_select_o,
  output logic [7:0]  bus_value_o,
  output logic        long_wait_o,
  output logic        last_o
);

  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned AW_C  = $clog2(COLUMNS);
  localparam int unsigned DEPTH = 2 * (2 ** AW_C);

  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_UP_H     = 8'h48;
  localparam logic [7:0] CH_UP_J     = 8'h4A;
  localparam logic [7:0] CH_UP_K     = 8'h4B;
  localparam logic [7:0] CH_BRACKET  = 8'h5B;
  localparam logic [7:0] CH_LOW_H    = 8'h68;
  localparam logic [7:0] CH_LOW_L    = 8'h6C;
  localparam logic [7:0] PARAM_CUR   = 8'd25;
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_END    = 2'd2;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESC    = 4'b0010,
    MODE_CSI    = 4'b0100,
    MODE_SPEC   = 4'b1000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [7:0]  p1_q, p1_d, p2_q, p2_d;
  logic [1:0]  slot_q, slot_d;
  act_e        act_q, act_d;
  logic [7:0]  char_q;

  logic        is_digit, printable, do_digit, do_slot;
  act_e        nrm_act;
  logic [7:0]  acc, sat;
  logic [11:0] prod;

  // escape parser, evaluated on the incoming byte
  always_comb begin
    mode_d   = mode_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    slot_d   = slot_q;
    act_d    = ACT_NONE;
    do_digit = 1'b0;
    do_slot  = 1'b0;

    is_digit  = (char_byte_i >= CH_ZERO) && (char_byte_i <= CH_NINE);
    printable = (char_byte_i >= CH_SPACE) && !char_byte_i[7];
    if (printable) begin
      nrm_act = ACT_PRINT;
    end else if (char_byte_i == CH_LF) begin
      nrm_act = ACT_NEWLINE;
    end else begin
      nrm_act = ACT_NONE;
    end

    // parameter accumulate, v*10+d saturating
    acc  = (slot_q == SLOT_FIRST) ? p1_q : p2_q;
    prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, char_byte_i[3:0]};
    sat  = (prod > 12'd255) ? 8'hFF : prod[7:0];

    unique case (mode_q)
      MODE_NORMAL: begin
        act_d = nrm_act;
        if (char_byte_i == CH_ESC) begin
          mode_d = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (char_byte_i == CH_BRACKET) begin
          mode_d = MODE_CSI;
          p1_d   = '0;
          p2_d   = '0;
          slot_d = SLOT_FIRST;
        end else if (char_byte_i != CH_ESC) begin
          mode_d = MODE_NORMAL;
          act_d  = nrm_act;
        end
      end
      MODE_CSI: begin
        if (is_digit) begin
          do_digit = 1'b1;
        end else if (char_byte_i == CH_SEMI) begin
          do_slot = 1'b1;
        end else if (char_byte_i == CH_QUEST) begin
          p1_d   = '0;
          p2_d   = '0;
          slot_d = SLOT_FIRST;
          mode_d = MODE_SPEC;
        end else begin
          mode_d = MODE_NORMAL;
          if (char_byte_i == CH_UP_J) begin
            act_d = ACT_CLEAR;
          end else if (char_byte_i == CH_UP_K) begin
            act_d = ACT_ERASE;
          end else if (char_byte_i == CH_UP_H) begin
            act_d = ACT_HOME;
          end
        end
      end
      MODE_SPEC: begin
        if (is_digit) begin
          do_digit = 1'b1;
        end else if (char_byte_i == CH_SEMI) begin
          do_slot = 1'b1;
        end else begin
          mode_d = MODE_NORMAL;
          if (char_byte_i == CH_LOW_L && p1_q == PARAM_CUR) begin
            act_d = ACT_CUR_ON;
          end else if (char_byte_i == CH_LOW_H && p1_q == PARAM_CUR) begin
            act_d = ACT_CUR_OFF;
          end
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
      end
    endcase

    if (do_digit) begin
      if (slot_q == SLOT_FIRST) begin
        p1_d = sat;
      end else if (slot_q == SLOT_SECOND) begin
        p2_d = sat;
      end
    end
    if (do_slot && slot_q != SLOT_END) begin
      slot_d = slot_q + 2'd1;
      if (slot_q == SLOT_FIRST) begin
        p2_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      p1_q   <= '0;
      p2_q   <= '0;
      slot_q <= SLOT_FIRST;
      act_q  <= ACT_NONE;
    end else if (cmd_i.take) begin
      mode_q <= mode_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      slot_q <= slot_d;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      char_q <= char_byte_i;
    end
  end

  // cursor, row mapping and shadow valid bits
  logic [CW-1:0]      col_q, col_d;
  logic [1:0]         row_q, row_d;
  logic               moved_q, moved_d;
  logic               top_q, top_d;
  logic [AW_C-1:0]    cnt_q, cnt_d;
  logic [COLUMNS-1:0] vld_q [2];
  logic [COLUMNS-1:0] vld_d [2];
  logic               prow;
  logic [AW_C-1:0]    col_idx, col_rd;

  assign prow    = row_q[0] ^ top_q;
  assign col_idx = col_q[AW_C-1:0];
  assign col_rd  = (cmd_i.cnt_op == CNT_ZERO) ? '0 : cnt_q + 1'b1;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    moved_d = moved_q;
    top_d   = top_q;
    vld_d   = vld_q;
    cnt_d   = cnt_q;

    unique case (cmd_i.cur_op)
      CUR_NONE: begin
      end
      CUR_WRAP: begin
        if (col_q >= CW'(COLUMNS)) begin
          col_d   = '0;
          row_d   = row_q + 2'd1;
          moved_d = 1'b1;
        end else begin
          moved_d = 1'b0;
        end
      end
      CUR_NEWLINE: begin
        col_d   = '0;
        row_d   = row_q + 2'd1;
        moved_d = 1'b1;
      end
      CUR_SCROLLED: begin
        col_d        = '0;
        row_d        = 2'd1;
        moved_d      = 1'b1;
        top_d        = ~top_q;
        vld_d[top_q] = '0;
      end
      CUR_GOTO: begin
        col_d = (p1_q >= 8'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(p1_q);
        row_d = (p2_q != 8'h00) ? 2'd1 : 2'd0;
      end
      CUR_HOME: begin
        col_d    = '0;
        row_d    = '0;
        vld_d[0] = '0;
        vld_d[1] = '0;
      end
      CUR_ADVANCE: begin
        col_d                = col_q + 1'b1;
        vld_d[prow][col_idx] = 1'b1;
      end
      default: begin
      end
    endcase

    // erase-to-end-of-line blanks one cell per write
    if (cmd_i.erase) begin
      vld_d[prow][cnt_q] = 1'b0;
    end

    unique case (cmd_i.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_ZERO: cnt_d = '0;
      CNT_INC:  cnt_d = cnt_q + 1'b1;
      CNT_COL:  cnt_d = col_idx;
      default:  cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      moved_q <= 1'b0;
      top_q   <= 1'b0;
      cnt_q   <= '0;
      vld_q   <= '{default: '0};
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      moved_q <= moved_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
    end
  end

  // screen shadow store, read during scroll redraw
  logic [7:0] rdata;
  logic       rd_vld_q;
  logic [7:0] shadow_byte;

  atlcd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cur_op == CUR_ADVANCE),
    .waddr_i ({prow, col_idx}),
    .wdata_i (char_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i ({~top_q, col_rd}),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_vld_q <= vld_q[~top_q][col_rd];
    end
  end

  assign shadow_byte = rd_vld_q ? rdata : CH_SPACE;

  // write byte selection
  logic [CW-1:0] col_clamp;
  logic [7:0]    loc_byte;
  logic          rs_d, long_d;
  logic [7:0]    bus_d;

  assign col_clamp = (col_q >= CW'(COLUMNS)) ? CW'(COLUMNS - 1) : col_q;
  assign loc_byte  = LCD_LOCATE | ((row_q != 2'd0) ? LCD_ROW1 : 8'h00) | 8'(col_clamp);

  always_comb begin
    rs_d   = 1'b0;
    long_d = 1'b0;
    bus_d  = LCD_CLEAR;
    unique case (cmd_i.sel)
      EMIT_CLEAR: begin
        bus_d  = LCD_CLEAR;
        long_d = 1'b1;
      end
      EMIT_HOME:   bus_d = LCD_LOCATE;
      EMIT_ENTRY:  bus_d = LCD_ENTRY;
      EMIT_LOCATE: bus_d = loc_byte;
      EMIT_SHADOW: begin
        rs_d  = 1'b1;
        bus_d = shadow_byte;
      end
      EMIT_SPACE: begin
        rs_d  = 1'b1;
        bus_d = CH_SPACE;
      end
      EMIT_CHAR: begin
        rs_d  = 1'b1;
        bus_d = char_q;
      end
      EMIT_CURSOR: bus_d = (act_q == ACT_CUR_ON) ? LCD_CUR_SHOWN : LCD_CUR_HIDDEN;
      default:     bus_d = LCD_CLEAR;
    endcase
  end

  // output register
  logic       out_valid_q;
  logic       rs_q, long_q, last_q;
  logic [7:0] bus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rs_q   <= rs_d;
      bus_q  <= bus_d;
      long_q <= long_d;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign register_select_o = rs_q;
  assign bus_value_o       = bus_q;
  assign long_wait_o       = long_q;
  assign last_o            = last_q;

  // status to the controller
  assign stat_o.act      = act_q;
  assign stat_o.moved    = moved_q;
  assign stat_o.row_over = row_q[1];
  assign stat_o.cnt_last = (cnt_q == AW_C'(COLUMNS - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/core/atlcd_ctrl.sv -----
module atlcd_ctrl import atlcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  atlcd_stat_t stat_i,
  output atlcd_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_DISP     = 14'b00000000000010,
    ST_CHK      = 14'b00000000000100,
    ST_SCR_CLR  = 14'b00000000001000,
    ST_SCR_LOC  = 14'b00000000010000,
    ST_SCR_ENT  = 14'b00000000100000,
    ST_SCR_DATA = 14'b00000001000000,
    ST_POST     = 14'b00000010000000,
    ST_LOC_PRE  = 14'b00000100000000,
    ST_PRINT    = 14'b00001000000000,
    ST_ERASE    = 14'b00010000000000,
    ST_LOC      = 14'b00100000000000,
    ST_JCLR     = 14'b01000000000000,
    ST_CUR      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   free;

  assign free       = stat_i.out_free;
  assign in_ready_o = (state_q == ST_IDLE);

  // sequencing of lcd writes for one byte
  always_comb begin
    state_d       = state_q;
    cmd_o.take    = in_valid_i && (state_q == ST_IDLE);
    cmd_o.emit    = 1'b0;
    cmd_o.sel     = EMIT_CLEAR;
    cmd_o.last    = 1'b0;
    cmd_o.cur_op  = CUR_NONE;
    cmd_o.cnt_op  = CNT_HOLD;
    cmd_o.rd_en   = 1'b0;
    cmd_o.erase   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (stat_i.act)
          ACT_NONE: state_d = ST_IDLE;
          ACT_PRINT, ACT_ERASE: begin
            cmd_o.cur_op = CUR_WRAP;
            state_d      = ST_CHK;
          end
          ACT_NEWLINE: begin
            cmd_o.cur_op = CUR_NEWLINE;
            state_d      = ST_CHK;
          end
          ACT_CLEAR: state_d = ST_JCLR;
          ACT_HOME: begin
            cmd_o.cur_op = CUR_GOTO;
            state_d      = ST_LOC;
          end
          ACT_CUR_ON, ACT_CUR_OFF: state_d = ST_CUR;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_CHK: begin
        state_d = stat_i.row_over ? ST_SCR_CLR : ST_POST;
      end
      ST_SCR_CLR: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_CLEAR;
          state_d    = ST_SCR_LOC;
        end
      end
      ST_SCR_LOC: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_HOME;
          state_d    = ST_SCR_ENT;
        end
      end
      ST_SCR_ENT: begin
        // prefetch the first cell of the row moving up
        if (free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.sel    = EMIT_ENTRY;
          cmd_o.rd_en  = 1'b1;
          cmd_o.cnt_op = CNT_ZERO;
          state_d      = ST_SCR_DATA;
        end
      end
      ST_SCR_DATA: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_SHADOW;
          if (stat_i.cnt_last) begin
            cmd_o.cur_op = CUR_SCROLLED;
            state_d      = ST_POST;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.cnt_op = CNT_INC;
          end
        end
      end
      ST_POST: begin
        priority if (stat_i.act == ACT_PRINT) begin
          state_d = stat_i.moved ? ST_LOC_PRE : ST_PRINT;
        end else if (stat_i.act == ACT_ERASE) begin
          cmd_o.cnt_op = CNT_COL;
          state_d      = stat_i.moved ? ST_LOC_PRE : ST_ERASE;
        end else begin
          state_d = ST_LOC;
        end
      end
      ST_LOC_PRE: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_LOCATE;
          state_d    = (stat_i.act == ACT_ERASE) ? ST_ERASE : ST_PRINT;
        end
      end
      ST_PRINT: begin
        if (free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.sel    = EMIT_CHAR;
          cmd_o.last   = 1'b1;
          cmd_o.cur_op = CUR_ADVANCE;
          state_d      = ST_IDLE;
        end
      end
      ST_ERASE: begin
        if (free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.sel   = EMIT_SPACE;
          cmd_o.erase = 1'b1;
          if (stat_i.cnt_last) begin
            state_d = ST_LOC;
          end else begin
            cmd_o.cnt_op = CNT_INC;
          end
        end
      end
      ST_LOC: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_LOCATE;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_JCLR: begin
        if (free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.sel    = EMIT_CLEAR;
          cmd_o.last   = 1'b1;
          cmd_o.cur_op = CUR_HOME;
          state_d      = ST_IDLE;
        end
      end
      ST_CUR: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_CURSOR;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import atlcd_pkg::*;

  localparam int COLS = 16;
  localparam int ROWS = 2;
  localparam int DRAIN_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  // terminal bytes used by the stimulus and the predictor
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    PM_NORMAL = 2'd0,
    PM_ESC    = 2'd1,
    PM_CSI    = 2'd2,
    PM_SPEC   = 2'd3
  } parse_mode_e;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic       long_wait;
    logic       last;
  } lcd_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  atlcd_char_if char_if ();
  atlcd_wr_if   lcd_if ();

  ansi_text_to_char_lcd #(.COLUMNS(COLS)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .lcd_o  (lcd_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  parse_mode_e mode;
  logic [7:0]  par_x;
  logic [7:0]  par_y;
  logic [1:0]  par_slot;
  logic [4:0]  cur_col;
  logic [1:0]  cur_row;
  logic [7:0]  shadow [ROWS][COLS];

  lcd_write_t pending_writes [$];
  lcd_write_t exp_w;
  int         burst_len;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         counted_items;
  bit         idle_on = 1'b1;

  function automatic void push_write(logic rs, logic [7:0] val, logic lw);
    lcd_write_t w;
    w.rs = rs;
    w.bus = val;
    w.long_wait = lw;
    w.last = 1'b0;
    pending_writes.push_back(w);
    burst_len++;
  endfunction

  function automatic void push_locate(logic [4:0] col, logic [1:0] row);
    logic [7:0] c;
    c = (col >= COLS) ? 8'(COLS - 1) : 8'(col);
    push_write(1'b0, LCD_LOCATE | ((row != 0) ? LCD_ROW1 : 8'h00) | c, 1'b0);
  endfunction

  function automatic void blank_shadow();
    int r, c;
    for (r = 0; r < ROWS; r++) begin
      for (c = 0; c < COLS; c++) shadow[r][c] = CH_SPACE;
    end
  endfunction

  function automatic void clear_params();
    par_x = 8'd0;
    par_y = 8'd0;
    par_slot = 2'd0;
  endfunction

  // pending wrap, then scroll by redrawing row 0 after moving row 1 up
  function automatic void settle_cursor(logic always_locate);
    logic moved;
    int i;
    moved = 1'b0;
    if (cur_col >= COLS) begin
      cur_col = 5'd0;
      cur_row++;
      moved = 1'b1;
    end
    if (cur_row >= ROWS) begin
      for (i = 0; i < COLS; i++) begin
        shadow[0][i] = shadow[1][i];
        shadow[1][i] = CH_SPACE;
      end
      push_write(1'b0, LCD_CLEAR, 1'b1);
      push_locate(5'd0, 2'd0);
      push_write(1'b0, LCD_ENTRY, 1'b0);
      for (i = 0; i < COLS; i++) push_write(1'b1, shadow[0][i], 1'b0);
      cur_col = 5'd0;
      cur_row = 2'(ROWS - 1);
      moved = 1'b1;
    end
    if (moved || always_locate) push_locate(cur_col, cur_row);
  endfunction

  // decimal parameter, saturating at 255, third slot ignored
  function automatic void add_digit(logic [3:0] d);
    int v;
    if (par_slot == 2'd0) v = par_x;
    else if (par_slot == 2'd1) v = par_y;
    else return;
    v = v * 10 + d;
    if (v > 255) v = 255;
    if (par_slot == 2'd0) par_x = 8'(v);
    else par_y = 8'(v);
  endfunction

  function automatic void next_slot();
    if (par_slot < 2'd2) begin
      par_slot++;
      if (par_slot == 2'd1) par_y = 8'd0;
    end
  endfunction

  function automatic void normal_byte(logic [7:0] ch);
    if (ch >= CH_SPACE && ch <= CH_DEL) begin
      settle_cursor(1'b0);
      shadow[cur_row[0]][cur_col] = ch;
      push_write(1'b1, ch, 1'b0);
      cur_col++;
    end else if (ch == CH_ESC) begin
      mode = PM_ESC;
    end else if (ch == CH_LF) begin
      cur_col = 5'd0;
      cur_row++;
      settle_cursor(1'b1);
    end
  endfunction

  // expected lcd writes for one accepted terminal byte
  function automatic void predict_lcd_writes(logic [7:0] ch);
    logic digit;
    int c;
    digit = (ch >= "0") && (ch <= "9");
    burst_len = 0;
    case (mode)
      PM_ESC: begin
        if (ch == "[") begin
          mode = PM_CSI;
          clear_params();
        end else if (ch != CH_ESC) begin
          mode = PM_NORMAL;
          normal_byte(ch);
        end
      end
      PM_CSI: begin
        if (digit) begin
          add_digit(4'(ch - "0"));
        end else if (ch == ";") begin
          next_slot();
        end else if (ch == "?") begin
          clear_params();
          mode = PM_SPEC;
        end else begin
          mode = PM_NORMAL;
          if (ch == "J") begin
            cur_col = 5'd0;
            cur_row = 2'd0;
            blank_shadow();
            push_write(1'b0, LCD_CLEAR, 1'b1);
          end else if (ch == "K") begin
            settle_cursor(1'b0);
            for (c = cur_col; c < COLS; c++) begin
              shadow[cur_row[0]][c] = CH_SPACE;
              push_write(1'b1, CH_SPACE, 1'b0);
            end
            push_locate(cur_col, cur_row);
          end else if (ch == "H") begin
            cur_col = (par_x >= COLS) ? 5'(COLS - 1) : par_x[4:0];
            cur_row = (par_y >= ROWS) ? 2'(ROWS - 1) : par_y[1:0];
            push_locate(cur_col, cur_row);
          end
        end
      end
      PM_SPEC: begin
        if (digit) begin
          add_digit(4'(ch - "0"));
        end else if (ch == ";") begin
          next_slot();
        end else begin
          mode = PM_NORMAL;
          if (ch == "l" && par_x == 8'd25) push_write(1'b0, LCD_CUR_SHOWN, 1'b0);
          else if (ch == "h" && par_x == 8'd25) push_write(1'b0, LCD_CUR_HIDDEN, 1'b0);
        end
      end
      default: normal_byte(ch);
    endcase
    if (burst_len > 0) pending_writes[pending_writes.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %02h, actual %02h", $time, what, exp_v, act_v);
    end
  endfunction

  // lcd side: compare each write transaction, random stalls, quiet counter
  always @(posedge clk_i) begin
    if (lcd_if.valid && lcd_if.ready) begin
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected lcd write: expected none, actual rs=%0b bus=%02h wait=%0b last=%0b",
                 $time, lcd_if.register_select, lcd_if.bus_value, lcd_if.long_wait,
                 lcd_if.last);
      end else begin
        exp_w = pending_writes.pop_front();
        check_field("register_select", 8'(exp_w.rs), 8'(lcd_if.register_select));
        check_field("bus_value", exp_w.bus, lcd_if.bus_value);
        check_field("long_wait", 8'(exp_w.long_wait), 8'(lcd_if.long_wait));
        check_field("last", 8'(exp_w.last), 8'(lcd_if.last));
      end
    end
    if ((lcd_if.valid && lcd_if.ready) || (char_if.valid && char_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    lcd_if.ready <= !(idle_on && ($urandom_range(99) < 12));
  end

  // watchdog on cycles without any transaction
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  // one terminal byte transaction, with a random gap in front
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (idle_on && ($urandom_range(99) < 12)) gap++;
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.char_byte <= b;
    do @(posedge clk_i); while (!char_if.ready);
    predict_lcd_writes(b);
    counted_items++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_number(input int v);
    send_text($sformatf("%0d", v));
  endtask

  // hold the sender until every expected write has come out
  task automatic wait_drained();
    char_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // printable extremes and ignored bytes
  task automatic test_print_and_ignored();
    send_byte(CH_SPACE);
    send_byte(CH_DEL);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
  endtask

  // saturated and clamped move, erase over a pending wrap, newline scroll
  task automatic test_move_erase_scroll();
    send_byte(CH_ESC);
    send_text("[999;1;7H");
    send_byte("a");
    send_byte(CH_ESC);
    send_text("[K");
    send_byte(CH_LF);
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    send_byte("c");
  endtask

  task automatic test_clear();
    send_byte(CH_ESC);
    send_text("[J");
  endtask

  // cursor show and hide, unknown final byte
  task automatic test_private_cursor();
    send_byte(CH_ESC);
    send_text("[?25l");
    send_byte(CH_ESC);
    send_text("[?25h");
    send_byte(CH_ESC);
    send_text("[Q");
  endtask

  // one random token: text, newline, escape sequence, noise or broken sequence
  task automatic send_random_token();
    int kind, n, i;
    kind = $urandom_range(99);
    if (kind < 40) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(CH_SPACE, CH_DEL)));
    end else if (kind < 50) begin
      send_byte(CH_LF);
    end else if (kind < 62) begin
      send_byte(CH_ESC);
      send_byte("[");
      if ($urandom_range(3) != 0)
        send_number(($urandom_range(7) == 0) ? $urandom_range(999) : $urandom_range(COLS + 3));
      if ($urandom_range(3) != 0) begin
        send_byte(";");
        if ($urandom_range(3) != 0) send_number($urandom_range(3));
      end
      if ($urandom_range(7) == 0) begin
        send_byte(";");
        send_number($urandom_range(99));
      end
      send_byte("H");
    end else if (kind < 68) begin
      send_byte(CH_ESC);
      send_byte("[");
      if ($urandom_range(3) == 0) send_number($urandom_range(2));
      send_byte("K");
    end else if (kind < 71) begin
      send_byte(CH_ESC);
      send_text("[J");
    end else if (kind < 80) begin
      send_byte(CH_ESC);
      send_text("[?");
      send_number(($urandom_range(3) != 0) ? 25 : $urandom_range(300));
      if ($urandom_range(5) == 0) begin
        send_byte(";");
        send_number($urandom_range(30));
      end
      send_byte($urandom_range(1) ? "l" : "h");
    end else if (kind < 90) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(CH_ESC);
      if ($urandom_range(1)) begin
        send_byte("[");
        if ($urandom_range(1)) send_number($urandom_range(40));
      end
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // random stream in three stretches, the middle one without idling
  task automatic test_random_stream();
    counted_items = 0;
    idle_on = 1'b1;
    while (counted_items < 95) send_random_token();
    wait_drained();
    idle_on = 1'b0;
    while (counted_items < 155) send_random_token();
    idle_on = 1'b1;
    while (counted_items < 220) send_random_token();
  endtask

  initial begin
    rst_ni <= 1'b0;
    char_if.valid <= 1'b0;
    char_if.char_byte <= 8'h00;
    mode = PM_NORMAL;
    clear_params();
    cur_col = 5'd0;
    cur_row = 2'd0;
    blank_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_print_and_ignored();
    test_move_erase_scroll();
    test_clear();
    test_private_cursor();
    test_random_stream();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/atlcd_pkg.sv
rtl/core/atlcd_if.sv
rtl/core/atlcd_ram.sv
rtl/core/atlcd_dp.sv
rtl/core/atlcd_ctrl.sv
rtl/core/ansi_text_to_char_lcd.sv
tb/testbench.sv
